// ----- rtl/dcd_pkg.sv -----
// Shared types and constants of the directed cycle detector.
package dcd_pkg;

	localparam int NODE_W = 8;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 9;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 9'd256;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_CHECK = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TS_INIT,
		TS_IDLE,
		TS_CLEAR,
		TS_CHECK
	} top_state_t;

	typedef enum logic [2:0] {
		SR_IDLE,
		SR_MCLR,
		SR_ROOT,
		SR_ROOTCHK,
		SR_EDGE,
		SR_ADJ,
		SR_MARK,
		SR_POP
	} srch_state_t;

	typedef struct packed {
		logic done;
		logic cyclic;
	} srch_res_t;

endpackage

// ----- rtl/dcd_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module dcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, and register the read word (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/dcd_search.sv -----
// Depth-first search engine with mark and stack memories for the cycle check.
module dcd_search import dcd_pkg::*; #(
	parameter int MAX_NODES  = 256,
	parameter int MAX_DEGREE = 8,
	localparam int NW = $clog2(MAX_NODES),
	localparam int CW = $clog2(MAX_NODES + 1),
	localparam int DW = $clog2(MAX_DEGREE + 1),
	localparam int AW = $clog2(MAX_NODES * MAX_DEGREE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [CW-1:0]     n,
	output logic [NW-1:0]     deg_raddr,
	input  logic [DW-1:0]     deg_rdata,
	output logic [AW-1:0]     adj_raddr,
	input  logic [NODE_W-1:0] adj_rdata,
	output srch_res_t         res
);

	localparam int SLW = (CW > NODE_W) ? CW : NODE_W;
	localparam int SEW = NW + 2 * DW;
	localparam logic [CW-1:0] SWEEP_LAST = CW'(MAX_NODES - 1);
	localparam logic [AW-1:0] MAXD_A     = AW'(MAX_DEGREE);

	// mark word: {visited, on current path}
	localparam logic [1:0] MARK_NONE = 2'b00;
	localparam logic [1:0] MARK_PATH = 2'b11;
	localparam logic [1:0] MARK_DONE = 2'b10;

	srch_state_t state_q, state_d;
	logic [CW-1:0] s_q;
	logic [CW-1:0] depth_q;
	logic [NW-1:0] v_q;
	logic [DW-1:0] k_q;
	logic [DW-1:0] dg_q;
	logic [NW-1:0] w_q;

	logic           mark_we;
	logic [NW-1:0]  mark_waddr;
	logic [1:0]     mark_wdata;
	logic [NW-1:0]  mark_raddr;
	logic [1:0]     mark_rdata;
	logic           stack_we;
	logic [NW-1:0]  stack_waddr;
	logic [SEW-1:0] stack_wdata;
	logic [NW-1:0]  stack_raddr;
	logic [SEW-1:0] stack_rdata;

	logic          k_more;
	logic          w_skip;
	logic          root_end;
	logic          mk_vis;
	logic          mk_on;
	logic [CW-1:0] dep_m1;
	logic [CW-1:0] dep_m2;
	logic [NW-1:0] s_idx;
	logic [NW-1:0] w_idx;

	dcd_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_mark (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(mark_wdata),
		.raddr(mark_raddr),
		.rdata(mark_rdata)
	);

	dcd_ram #(.WIDTH(SEW), .DEPTH(MAX_NODES)) u_stack (
		.clk  (clk),
		.we   (stack_we),
		.waddr(stack_waddr),
		.wdata(stack_wdata),
		.raddr(stack_raddr),
		.rdata(stack_rdata)
	);

	// decode the current step
	always_comb begin
		k_more   = (k_q < dg_q);
		w_skip   = (SLW'(adj_rdata) == SLW'(v_q)) || (SLW'(adj_rdata) >= SLW'(n));
		root_end = (s_q >= n);
		mk_vis   = mark_rdata[1];
		mk_on    = mark_rdata[0];
		dep_m1   = depth_q - CW'(1);
		dep_m2   = depth_q - CW'(2);
		s_idx    = s_q[NW-1:0];
		w_idx    = NW'(adj_rdata);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SR_IDLE: begin
				if (go) begin
					state_d = SR_MCLR;
				end
			end
			SR_MCLR: begin
				if (s_q == SWEEP_LAST) begin
					state_d = SR_ROOT;
				end
			end
			SR_ROOT: begin
				state_d = root_end ? SR_IDLE : SR_ROOTCHK;
			end
			SR_ROOTCHK: begin
				state_d = mk_vis ? SR_ROOT : SR_EDGE;
			end
			SR_EDGE: begin
				if (k_more) begin
					state_d = SR_ADJ;
				end else if (depth_q == CW'(1)) begin
					state_d = SR_ROOT;
				end else begin
					state_d = SR_POP;
				end
			end
			SR_ADJ: begin
				state_d = w_skip ? SR_EDGE : SR_MARK;
			end
			SR_MARK: begin
				state_d = (mk_vis && mk_on) ? SR_IDLE : SR_EDGE;
			end
			SR_POP: begin
				state_d = SR_EDGE;
			end
			default: begin
				state_d = SR_IDLE;
			end
		endcase
	end

	// memory controls and result
	always_comb begin
		mark_we     = 1'b0;
		mark_waddr  = s_idx;
		mark_wdata  = MARK_NONE;
		mark_raddr  = w_idx;
		deg_raddr   = w_idx;
		stack_we    = 1'b0;
		stack_waddr = dep_m1[NW-1:0];
		stack_wdata = {v_q, k_q, dg_q};
		stack_raddr = dep_m2[NW-1:0];
		adj_raddr   = AW'(v_q) * MAXD_A + AW'(k_q);
		res         = '0;
		unique case (state_q)
			SR_IDLE: begin
			end
			SR_MCLR: begin
				mark_we = 1'b1;
			end
			SR_ROOT: begin
				mark_raddr = s_idx;
				deg_raddr  = s_idx;
				res.done   = root_end;
			end
			SR_ROOTCHK: begin
				mark_we    = !mk_vis;
				mark_wdata = MARK_PATH;
			end
			SR_EDGE: begin
				// leaving a node: drop it from the path
				mark_we    = !k_more;
				mark_waddr = v_q;
				mark_wdata = MARK_DONE;
			end
			SR_ADJ: begin
			end
			SR_MARK: begin
				if (!mk_vis) begin
					stack_we   = 1'b1;
					mark_we    = 1'b1;
					mark_waddr = w_q;
					mark_wdata = MARK_PATH;
				end else if (mk_on) begin
					res.done   = 1'b1;
					res.cyclic = 1'b1;
				end
			end
			SR_POP: begin
			end
			default: begin
			end
		endcase
	end

	// control registers: state, root counter, stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SR_IDLE;
			s_q     <= '0;
			depth_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				SR_IDLE: begin
					if (go) begin
						s_q <= '0;
					end
				end
				SR_MCLR: begin
					s_q <= (s_q == SWEEP_LAST) ? '0 : s_q + CW'(1);
				end
				SR_ROOTCHK: begin
					if (mk_vis) begin
						s_q <= s_q + CW'(1);
					end else begin
						depth_q <= CW'(1);
					end
				end
				SR_EDGE: begin
					if (!k_more) begin
						depth_q <= dep_m1;
						if (depth_q == CW'(1)) begin
							s_q <= s_q + CW'(1);
						end
					end
				end
				SR_MARK: begin
					if (!mk_vis) begin
						depth_q <= depth_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// top-of-stack registers: node, next edge position, degree
	always_ff @(posedge clk) begin
		case (state_q)
			SR_ROOTCHK: begin
				v_q  <= s_idx;
				k_q  <= '0;
				dg_q <= deg_rdata;
			end
			SR_EDGE: begin
				if (k_more) begin
					k_q <= k_q + DW'(1);
				end
			end
			SR_ADJ: begin
				w_q <= w_idx;
			end
			SR_MARK: begin
				if (!mk_vis) begin
					v_q  <= w_q;
					k_q  <= '0;
					dg_q <= deg_rdata;
				end
			end
			SR_POP: begin
				{v_q, k_q, dg_q} <= stack_rdata;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/directed_cycle_detector.sv -----
// Add edge and unused op: result in the cycle after the beat, one beat per cycle.
// Clear: sweep that zeroes the degree memory, result in the cycle of its last write.
// Check: mark memory sweep, then a depth-first search from each unvisited root; it skips
// self-loop and out-of-range edges and tests the rest; result on the deciding cycle.
// Reset: degree clearing pass with busy high; node_count resets to 256.
// Results are strobed by done for one cycle; the receiver cannot stall.
module directed_cycle_detector import dcd_pkg::*; #(
	parameter int MAX_NODES  = 256,
	parameter int MAX_DEGREE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [NODE_W-1:0] src_node,
	input  logic [NODE_W-1:0] dst_node,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic              cyclic,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam int AW = $clog2(MAX_NODES * MAX_DEGREE);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [LW-1:0] MAXN_L     = LW'(MAX_NODES);
	localparam logic [CW-1:0] SWEEP_LAST = CW'(MAX_NODES - 1);
	localparam logic [DW-1:0] MAXD_D     = DW'(MAX_DEGREE);
	localparam logic [AW-1:0] MAXD_A     = AW'(MAX_DEGREE);

	top_state_t state_q, state_d;
	logic [CFG_W-1:0] node_count_q;
	logic [CW-1:0]    sweep_q;

	logic              vld_s1;
	op_t               op_s1;
	logic [NODE_W-1:0] src_s1;
	logic [NODE_W-1:0] dst_s1;
	logic              range_bad_s1;
	logic              fwd_hit_s1;
	logic [DW-1:0]     fwd_deg_s1;

	op_t           op_in;
	logic          accept;
	logic          sweeping;
	logic          clr_last;
	logic          srch_go;
	logic [CW-1:0] n_eff;
	logic          range_bad_in;
	logic [DW-1:0] deg_cur;
	logic [DW-1:0] deg_new;
	logic          add_ok;
	status_t       stat_s1;

	logic          deg_we;
	logic [NW-1:0] deg_waddr;
	logic [DW-1:0] deg_wdata;
	logic [NW-1:0] deg_raddr;
	logic [DW-1:0] deg_rdata;
	logic [NW-1:0] srch_deg_raddr;
	logic [AW-1:0] adj_waddr;
	logic [AW-1:0] adj_raddr;
	logic [NODE_W-1:0] adj_rdata;
	srch_res_t     srch_res;

	dcd_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_degree (
		.clk  (clk),
		.we   (deg_we),
		.waddr(deg_waddr),
		.wdata(deg_wdata),
		.raddr(deg_raddr),
		.rdata(deg_rdata)
	);

	dcd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES * MAX_DEGREE)) u_adjacency (
		.clk  (clk),
		.we   (add_ok),
		.waddr(adj_waddr),
		.wdata(dst_s1),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	dcd_search #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE)) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (srch_go),
		.n        (n_eff),
		.deg_raddr(srch_deg_raddr),
		.deg_rdata(deg_rdata),
		.adj_raddr(adj_raddr),
		.adj_rdata(adj_rdata),
		.res      (srch_res)
	);

	// command decode and edge load datapath
	always_comb begin
		op_in        = op_t'(op);
		accept       = start && !busy;
		n_eff        = (LW'(node_count_q) > MAXN_L) ? CW'(MAX_NODES) : CW'(node_count_q);
		range_bad_in = (LW'(src_node) >= LW'(n_eff)) || (LW'(dst_node) >= LW'(n_eff));
		deg_cur      = fwd_hit_s1 ? fwd_deg_s1 : deg_rdata;
		deg_new      = deg_cur + DW'(1);
		add_ok       = vld_s1 && (op_s1 == OP_ADD) && !range_bad_s1 && (deg_cur < MAXD_D);
		adj_waddr    = AW'(src_s1) * MAXD_A + AW'(deg_cur);
		if (range_bad_s1 && (op_s1 == OP_ADD)) begin
			stat_s1 = STAT_RANGE;
		end else if ((op_s1 == OP_ADD) && (deg_cur >= MAXD_D)) begin
			stat_s1 = STAT_FULL;
		end else begin
			stat_s1 = STAT_OK;
		end
	end

	// degree memory ports: sweep or edge load write, search or load read
	always_comb begin
		deg_we    = sweeping || add_ok;
		deg_waddr = sweeping ? sweep_q[NW-1:0] : NW'(src_s1);
		deg_wdata = sweeping ? '0 : deg_new;
		deg_raddr = (state_q == TS_CHECK) ? srch_deg_raddr : NW'(src_node);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_INIT: begin
				if (sweep_q == SWEEP_LAST) begin
					state_d = TS_IDLE;
				end
			end
			TS_IDLE: begin
				if (accept && (op_in == OP_CLEAR)) begin
					state_d = TS_CLEAR;
				end else if (accept && (op_in == OP_CHECK)) begin
					state_d = TS_CHECK;
				end
			end
			TS_CLEAR: begin
				if (sweep_q == SWEEP_LAST) begin
					state_d = TS_IDLE;
				end
			end
			TS_CHECK: begin
				if (srch_res.done) begin
					state_d = TS_IDLE;
				end
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy      = (state_q != TS_IDLE);
		sweeping  = (state_q == TS_INIT) || (state_q == TS_CLEAR);
		clr_last  = (state_q == TS_CLEAR) && (sweep_q == SWEEP_LAST);
		srch_go   = accept && (op_in == OP_CHECK);
		cfg_ready = !busy;
		done      = vld_s1 || clr_last || srch_res.done;
		status    = vld_s1 ? stat_s1 : STAT_OK;
		cyclic    = srch_res.done && srch_res.cyclic;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= TS_INIT;
			sweep_q      <= '0;
			node_count_q <= NODE_COUNT_RST;
			vld_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sweeping) begin
				sweep_q <= (sweep_q == SWEEP_LAST) ? '0 : sweep_q + CW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			vld_s1 <= accept && ((op_in == OP_ADD) || (op_in == OP_NOP));
		end
	end

	// load stage payload; forward the degree just written to a back-to-back add
	always_ff @(posedge clk) begin
		op_s1        <= op_in;
		src_s1       <= src_node;
		dst_s1       <= dst_node;
		range_bad_s1 <= range_bad_in;
		fwd_hit_s1   <= add_ok && (src_s1 == src_node);
		fwd_deg_s1   <= deg_new;
	end

endmodule
